// ----- src/ecpt_pkg.sv -----
// ----------------------------------------------------------------------------
// ecpt_pkg
// shared widths, register map and types of the elliptic cylinder point test
// ----------------------------------------------------------------------------
package ecpt_pkg;

  // fixed field widths
  localparam int FIELD_W = 21;          // one input coordinate field
  localparam int VEC_W   = 63;          // packed vector register
  localparam int RAD_W   = 20;          // radius and height registers
  localparam int TOL_W   = 16;          // surface tolerance register

  // apb port
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;
  localparam int IDX_LSB = 3;           // registers on 8-byte spacing

  // ellipse datapath widths
  localparam int Q_W    = RAD_W + 1;            // clamped magnitude, up to 2*radius
  localparam int SQ_W   = 2 * Q_W;              // squared magnitude
  localparam int A2_W   = 2 * RAD_W;            // squared radius
  localparam int HALF_W = RAD_W;                // chunk for split products
  localparam int PP_W   = SQ_W + HALF_W;        // sq * radius-square chunk
  localparam int DP_W   = A2_W + HALF_W;        // a2 * b2 chunk
  localparam int NUM_W  = SQ_W + A2_W + 1;      // ellipse numerator
  localparam int DEN_W  = 2 * A2_W;             // a2 * b2
  localparam int TP_W   = TOL_W + HALF_W;       // tol * den chunk
  localparam int LIM_W  = TOL_W + DEN_W;        // tol * den
  localparam int SH_W   = NUM_W + TOL_W;        // diff scaled by 2^16
  localparam int DEN_CHUNKS = DEN_W / HALF_W;

  typedef enum logic [2:0] {
    REG_BASE_CENTER  = 3'd0,
    REG_AXIS_DIR     = 3'd1,
    REG_LONG_DIR     = 3'd2,
    REG_SHORT_DIR    = 3'd3,
    REG_LONG_RADIUS  = 3'd4,
    REG_SHORT_RADIUS = 3'd5,
    REG_CYL_HEIGHT   = 3'd6,
    REG_SURF_TOL     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [VEC_W-1:0] base_center;
    logic [VEC_W-1:0] axis_dir;
    logic [VEC_W-1:0] long_dir;
    logic [VEC_W-1:0] short_dir;
    logic [RAD_W-1:0] long_radius;
    logic [RAD_W-1:0] short_radius;
    logic [RAD_W-1:0] cyl_height;
    logic [TOL_W-1:0] surface_tolerance;
  } cfg_t;

  // handoff from projection to ellipse section
  typedef struct packed {
    logic           rej;   // outside height range or zero radius
    logic [Q_W-1:0] qx;    // clamped |lx| with frac bits
    logic [Q_W-1:0] qz;    // clamped |lz| with frac bits
  } proj_t;

endpackage

// ----- src/ecpt_regs.sv -----
// ----------------------------------------------------------------------------
// ecpt_regs
// apb register file holding the cylinder description
// ----------------------------------------------------------------------------
module ecpt_regs import ecpt_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output cfg_t              cfg_o
);

  localparam logic [VEC_W-1:0] AXIS_RST  = VEC_W'(1) << (FRAC_BITS + COORD_WIDTH);
  localparam logic [VEC_W-1:0] LONG_RST  = VEC_W'(1) << FRAC_BITS;
  localparam logic [VEC_W-1:0] SHORT_RST = VEC_W'(1) << (FRAC_BITS + 2 * COORD_WIDTH);
  localparam logic [RAD_W-1:0] ONE_RST   = RAD_W'(1) << FRAC_BITS;
  localparam logic [TOL_W-1:0] TOL_RST   = TOL_W'(7);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[APB_AW-1:IDX_LSB]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_center       <= '0;
      cfg_q.axis_dir          <= AXIS_RST;
      cfg_q.long_dir          <= LONG_RST;
      cfg_q.short_dir         <= SHORT_RST;
      cfg_q.long_radius       <= ONE_RST;
      cfg_q.short_radius      <= ONE_RST;
      cfg_q.cyl_height        <= ONE_RST;
      cfg_q.surface_tolerance <= TOL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_BASE_CENTER:  cfg_q.base_center       <= pwdata[VEC_W-1:0];
        REG_AXIS_DIR:     cfg_q.axis_dir          <= pwdata[VEC_W-1:0];
        REG_LONG_DIR:     cfg_q.long_dir          <= pwdata[VEC_W-1:0];
        REG_SHORT_DIR:    cfg_q.short_dir         <= pwdata[VEC_W-1:0];
        REG_LONG_RADIUS:  cfg_q.long_radius       <= pwdata[RAD_W-1:0];
        REG_SHORT_RADIUS: cfg_q.short_radius      <= pwdata[RAD_W-1:0];
        REG_CYL_HEIGHT:   cfg_q.cyl_height        <= pwdata[RAD_W-1:0];
        REG_SURF_TOL:     cfg_q.surface_tolerance <= pwdata[TOL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_CENTER:  prdata = APB_DW'(cfg_q.base_center);
      REG_AXIS_DIR:     prdata = APB_DW'(cfg_q.axis_dir);
      REG_LONG_DIR:     prdata = APB_DW'(cfg_q.long_dir);
      REG_SHORT_DIR:    prdata = APB_DW'(cfg_q.short_dir);
      REG_LONG_RADIUS:  prdata = APB_DW'(cfg_q.long_radius);
      REG_SHORT_RADIUS: prdata = APB_DW'(cfg_q.short_radius);
      REG_CYL_HEIGHT:   prdata = APB_DW'(cfg_q.cyl_height);
      REG_SURF_TOL:     prdata = APB_DW'(cfg_q.surface_tolerance);
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/ecpt_proj.sv -----
// ----------------------------------------------------------------------------
// ecpt_proj
// four-stage front end: offset, dot-product terms, sums, range check and clamp
// ----------------------------------------------------------------------------
module ecpt_proj import ecpt_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [FIELD_W-1:0] px_i,
  input  logic [FIELD_W-1:0] py_i,
  input  logic [FIELD_W-1:0] pz_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output proj_t              out_o
);

  localparam int C     = COORD_WIDTH;
  localparam int V_W   = C + 1;               // point minus base
  localparam int P_W   = V_W + C;             // one product term
  localparam int D_W   = P_W + 2;             // sum of three terms
  localparam int MAG_W = D_W - FRAC_BITS;     // truncated magnitude
  localparam int QC_W  = (MAG_W > Q_W) ? MAG_W : Q_W;
  localparam int CMP_W = (D_W > RAD_W + FRAC_BITS) ? D_W : RAD_W + FRAC_BITS;
  localparam int NSTG  = 4;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTG-1];

  // stage 1: offset from base center
  logic [FIELD_W-1:0]    pin [3];
  logic signed [V_W-1:0] v_d [3];
  logic signed [V_W-1:0] v_q [3];

  assign pin[0] = px_i;
  assign pin[1] = py_i;
  assign pin[2] = pz_i;

  always_comb begin
    logic [C-1:0] pc;
    logic [C-1:0] bc;
    for (int i = 0; i < 3; i++) begin
      pc     = pin[i][C-1:0];
      bc     = cfg_i.base_center[i*C +: C];
      v_d[i] = $signed({pc[C-1], pc}) - $signed({bc[C-1], bc});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) v_q <= v_d;
  end

  // stage 2: nine product terms, rows are long, axis, short
  logic [VEC_W-1:0]      dir [3];
  logic signed [P_W-1:0] prod_d [3][3];
  logic signed [P_W-1:0] prod_q [3][3];

  assign dir[0] = cfg_i.long_dir;
  assign dir[1] = cfg_i.axis_dir;
  assign dir[2] = cfg_i.short_dir;

  always_comb begin
    logic signed [C-1:0] dc;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        dc           = $signed(dir[r][i*C +: C]);
        prod_d[r][i] = P_W'(v_q[i]) * P_W'(dc);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) prod_q <= prod_d;
  end

  // stage 3: dot products lx, ly, lz
  logic signed [D_W-1:0] dot_d [3];
  logic signed [D_W-1:0] dot_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      dot_d[r] = D_W'(prod_q[r][0]) + D_W'(prod_q[r][1]) + D_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) dot_q <= dot_d;
  end

  // stage 4: height window, zero radius and clamped magnitudes
  proj_t out_d;
  proj_t out_q;

  function automatic logic [Q_W-1:0] clamp_mag(logic signed [D_W-1:0] x,
                                               logic [RAD_W-1:0] rad);
    logic [D_W-1:0]  mag;
    logic [QC_W-1:0] sh;
    logic [Q_W-1:0]  lim;
    mag = x[D_W-1] ? D_W'(-x) : D_W'(x);
    sh  = QC_W'(mag[D_W-1:FRAC_BITS]);
    lim = {rad, 1'b0};
    return (sh > QC_W'(lim)) ? lim : sh[Q_W-1:0];
  endfunction

  always_comb begin
    logic [CMP_W-1:0] ly_u;
    logic [CMP_W-1:0] h_u;
    logic             out_rng;
    ly_u      = CMP_W'($unsigned(dot_q[1]));
    h_u       = CMP_W'(cfg_i.cyl_height) << FRAC_BITS;
    out_rng   = dot_q[1][D_W-1] || (ly_u > h_u);
    out_d.rej = out_rng || (cfg_i.long_radius == '0) || (cfg_i.short_radius == '0);
    out_d.qx  = clamp_mag(dot_q[0], cfg_i.long_radius);
    out_d.qz  = clamp_mag(dot_q[2], cfg_i.short_radius);
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

// ----- src/ecpt_ellipse.sv -----
// ----------------------------------------------------------------------------
// ecpt_ellipse
// six-stage ellipse sum compare, multiplied through by the squared radii
// ----------------------------------------------------------------------------
module ecpt_ellipse import ecpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  proj_t in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output logic  inside_res_o,
  output logic  on_surface_o
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_q;
  logic [NSTG:0]   en;

  always_comb begin
    en[NSTG] = out_ready_i;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTG-1];

  // stage 1: squares of magnitudes and radii
  logic [SQ_W-1:0]  sqx_q, sqz_q;
  logic [A2_W-1:0]  a2_q, b2_q;
  logic [TOL_W-1:0] tol1_q;
  logic             rej1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      sqx_q  <= SQ_W'(in_i.qx) * SQ_W'(in_i.qx);
      sqz_q  <= SQ_W'(in_i.qz) * SQ_W'(in_i.qz);
      a2_q   <= A2_W'(cfg_i.long_radius) * A2_W'(cfg_i.long_radius);
      b2_q   <= A2_W'(cfg_i.short_radius) * A2_W'(cfg_i.short_radius);
      tol1_q <= cfg_i.surface_tolerance;
      rej1_q <= in_i.rej;
    end
  end

  // stage 2: partial products on half-width radius squares
  logic [PP_W-1:0]  xlo_q, xhi_q, zlo_q, zhi_q;
  logic [DP_W-1:0]  dlo_q, dhi_q;
  logic [TOL_W-1:0] tol2_q;
  logic             rej2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      xlo_q  <= PP_W'(sqx_q) * PP_W'(b2_q[HALF_W-1:0]);
      xhi_q  <= PP_W'(sqx_q) * PP_W'(b2_q[A2_W-1:HALF_W]);
      zlo_q  <= PP_W'(sqz_q) * PP_W'(a2_q[HALF_W-1:0]);
      zhi_q  <= PP_W'(sqz_q) * PP_W'(a2_q[A2_W-1:HALF_W]);
      dlo_q  <= DP_W'(a2_q) * DP_W'(b2_q[HALF_W-1:0]);
      dhi_q  <= DP_W'(a2_q) * DP_W'(b2_q[A2_W-1:HALF_W]);
      tol2_q <= tol1_q;
      rej2_q <= rej1_q;
    end
  end

  // stage 3: numerator and denominator
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q;
  logic [TOL_W-1:0] tol3_q;
  logic             rej3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      num_q  <= ((NUM_W'(xhi_q) + NUM_W'(zhi_q)) << HALF_W)
                + NUM_W'(xlo_q) + NUM_W'(zlo_q);
      den_q  <= (DEN_W'(dhi_q) << HALF_W) + DEN_W'(dlo_q);
      tol3_q <= tol2_q;
      rej3_q <= rej2_q;
    end
  end

  // stage 4: inside compare, distance from one, tolerance partials
  logic             in4_q;
  logic [NUM_W-1:0] diff4_q;
  logic [TP_W-1:0]  tp_q [DEN_CHUNKS];
  logic             rej4_q;
  logic [NUM_W-1:0] den_ext;

  assign den_ext = NUM_W'(den_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      in4_q   <= num_q <= den_ext;
      diff4_q <= (num_q >= den_ext) ? num_q - den_ext : den_ext - num_q;
      for (int k = 0; k < DEN_CHUNKS; k++) begin
        tp_q[k] <= TP_W'(tol3_q) * TP_W'(den_q[k*HALF_W +: HALF_W]);
      end
      rej4_q  <= rej3_q;
    end
  end

  // stage 5: tolerance limit
  logic             in5_q;
  logic [NUM_W-1:0] diff5_q;
  logic [LIM_W-1:0] lim_q;
  logic             rej5_q;
  logic [LIM_W-1:0] lim_d;

  always_comb begin
    lim_d = '0;
    for (int k = 0; k < DEN_CHUNKS; k++) begin
      lim_d = lim_d + (LIM_W'(tp_q[k]) << (k * HALF_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      in5_q   <= in4_q;
      diff5_q <= diff4_q;
      lim_q   <= lim_d;
      rej5_q  <= rej4_q;
    end
  end

  // stage 6: output register
  logic inside_q, surf_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      inside_q <= in5_q && !rej5_q;
      surf_q   <= ((SH_W'(diff5_q) << TOL_W) <= SH_W'(lim_q)) && !rej5_q;
    end
  end

  assign inside_res_o = inside_q;
  assign on_surface_o = surf_q;

endmodule

// ----- src/elliptic_cylinder_point_test.sv -----
// ----------------------------------------------------------------------------
// elliptic_cylinder_point_test
// tests a stream of 3-d points against an oriented elliptic cylinder
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        px, py, pz (signed q10.10)
//  m_axis    out        tvalid / tready        inside_res, on_surface
//  apb       in         psel/penable/pready    eight cylinder registers, 8-byte spaced
//
//  one point per cycle sustained while m_axis is not stalled; ten register stages
//  deep, each point passing through all of them before its result is valid
//  (4 projection stages, 6 ellipse stages, the last one the output register)
//  reset clears all stage valid bits and loads the unit cylinder registers
//  each stage holds while the one after it is full and stalled, so a stall on
//  m_axis fills bubbles first and only then drops s_axis_tready
// ----------------------------------------------------------------------------
module elliptic_cylinder_point_test import ecpt_pkg::*; #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_BITS   = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // point input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,   // px [20:0], py [41:21], pz [62:42], pad
  // test result output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // inside_res [0], on_surface [1], pad
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t  cfg;
  proj_t proj;
  logic  proj_valid;
  logic  ell_ready;
  logic  inside_res;
  logic  on_surface;

  // register file, no wait states
  assign pready = 1'b1;

  ecpt_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // offset, projection onto the three axes, height window and clamp
  ecpt_proj #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_proj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .px_i        (s_axis_tdata[FIELD_W-1:0]),
    .py_i        (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .pz_i        (s_axis_tdata[3*FIELD_W-1:2*FIELD_W]),
    .out_valid_o (proj_valid),
    .out_ready_i (ell_ready),
    .out_o       (proj)
  );

  // ellipse sum against one, cross-multiplied by the squared radii
  ecpt_ellipse u_ellipse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (proj_valid),
    .in_ready_o   (ell_ready),
    .in_i         (proj),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .inside_res_o (inside_res),
    .on_surface_o (on_surface)
  );

  assign m_axis_tdata = {6'b0, on_surface, inside_res};

  // input backpressure only ever comes from a stalled result
  a_ready_from_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result transfer");

  // handoff between the two pipeline sections holds its item
  a_handoff_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proj_valid && !ell_ready |=> proj_valid && $stable(proj))
    else $error("projection output changed while stalled");

endmodule
